@@ rtl/hmm_trace_validator_defines.svh @@
// Assertion macros shared by the trace validator RTL.
// Expects signals clk and rst in the scope of use.
`ifndef HMM_TRACE_VALIDATOR_DEFINES_SVH
`define HMM_TRACE_VALIDATOR_DEFINES_SVH

// Same-cycle implication.
`define HMMTV_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define HMMTV_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/hmmtv_pkg.sv @@
// Package for the trace validator: sizes, state type codes, error codes
// and the map port struct. No dependencies.
`timescale 1ns / 1ps
package hmmtv_pkg;
  localparam int MAX_SEQ_LEN = 4096;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROWS        = MAX_SEQ_LEN / WORD_W + 1;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int POS_W       = 13;
  localparam int NODE_W      = 12;
  localparam int TY_W        = 4;
  localparam int ERR_W       = 4;

  localparam logic [POS_W-1:0] CNT_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] LEN_MAX = POS_W'(MAX_SEQ_LEN);

  localparam logic [TY_W-1:0] TY_S = 4'd0;
  localparam logic [TY_W-1:0] TY_N = 4'd1;
  localparam logic [TY_W-1:0] TY_B = 4'd2;
  localparam logic [TY_W-1:0] TY_M = 4'd3;
  localparam logic [TY_W-1:0] TY_D = 4'd4;
  localparam logic [TY_W-1:0] TY_I = 4'd5;
  localparam logic [TY_W-1:0] TY_E = 4'd6;
  localparam logic [TY_W-1:0] TY_J = 4'd7;
  localparam logic [TY_W-1:0] TY_C = 4'd8;
  localparam logic [TY_W-1:0] TY_T = 4'd9;
  localparam logic [TY_W-1:0] TY_X = 4'd10;

  localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT     = 4'd1;
  localparam logic [ERR_W-1:0] ERR_FIRST     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_LAST      = 4'd3;
  localparam logic [ERR_W-1:0] ERR_FIRST_K   = 4'd4;
  localparam logic [ERR_W-1:0] ERR_FIRST_I   = 4'd5;
  localparam logic [ERR_W-1:0] ERR_LAST_K    = 4'd6;
  localparam logic [ERR_W-1:0] ERR_LAST_I    = 4'd7;
  localparam logic [ERR_W-1:0] ERR_MID_S     = 4'd8;
  localparam logic [ERR_W-1:0] ERR_MID_T     = 4'd9;
  localparam logic [ERR_W-1:0] ERR_CORE      = 4'd10;
  localparam logic [ERR_W-1:0] ERR_NODE      = 4'd11;
  localparam logic [ERR_W-1:0] ERR_POS       = 4'd12;
  localparam logic [ERR_W-1:0] ERR_TRANS     = 4'd13;
  localparam logic [ERR_W-1:0] ERR_RESIDUES  = 4'd14;

  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } map_req_t;

  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction
endpackage

@@ rtl/hmmtv_map.sv @@
// Residue map storage: one single-port word memory, registered read.
// Depends on hmmtv_pkg.
`timescale 1ns / 1ps
module hmmtv_map import hmmtv_pkg::*; (
  input  logic              clk,
  input  map_req_t          req,
  output logic [WORD_W-1:0] rdata
);
  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

@@ rtl/hmm_trace_validator.sv @@
// Alignment path validator top level: sequencer, grammar checks, map scan.
// Depends on hmmtv_pkg, hmmtv_map and hmm_trace_validator_defines.svh.
//
// Usage:
//   req channel (req_valid/req_ready) carries one beat per map column load
//   (req_type 0) or per path element (req_type 1). rsp channel
//   (rsp_valid/rsp_ready) carries one verdict beat per element with last set.
//   cfg_we/cfg_data write seq_length; write it only while idle.
// Steps:
//   A map load reads the word, then merge-writes the column bit. The first
//   path element is taken in the idle state with no scan. Every other element
//   reads and checks 32-column map words one at a time through the single
//   map port to find the next residue, at most 129 words, then applies its
//   checks. When the expected position is already past the sequence end no
//   word is checked. The last element forms its verdict in place of the final
//   update; the verdict is registered once the output register is free.
// Reset:
//   rst clears control state, then a sweep zeroes all 129 map words;
//   req_ready stays low during the sweep.
// Stall:
//   A verdict sits in an output register; the next items are still taken.
//   Only a second verdict waits until the first one is taken.
`timescale 1ns / 1ps
`include "hmm_trace_validator_defines.svh"
module hmm_trace_validator import hmmtv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [POS_W-1:0]  cfg_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              req_type,
  input  logic [POS_W-1:0]  column,
  input  logic              column_is_residue,
  input  logic [TY_W-1:0]   state_type,
  input  logic [NODE_W-1:0] model_node,
  input  logic [POS_W-1:0]  seq_pos,
  input  logic              last,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              path_ok,
  output logic [ERR_W-1:0]  error_code
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_SCAN_RD, S_SCAN_CHK, S_APPLY, S_FINISH
  } state_t;

  state_t state;

  // Config and latched request
  logic [POS_W-1:0]  seq_length;
  logic [POS_W-1:0]  len_eff;
  logic [TY_W-1:0]   cur_st;
  logic [NODE_W-1:0] cur_node;
  logic [POS_W-1:0]  cur_pos;
  logic              cur_last;
  logic [POS_W-1:0]  ld_col;
  logic              ld_bit;

  // Path state
  logic [1:0]        elements_seen;
  logic              core_mode;
  logic [TY_W-1:0]   held_st;
  logic [TY_W-1:0]   prior_st;
  logic [POS_W-1:0]  expected_node;
  logic [POS_W-1:0]  expected_pos;
  logic [2:0]        first_err;
  logic [ERR_W-1:0]  mid_err;
  logic [ROW_W-1:0]  clr_row;

  map_req_t          map_req;
  logic [WORD_W-1:0] map_rdata;

  hmmtv_map u_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (map_rdata)
  );

  assign len_eff = (seq_length > LEN_MAX) ? LEN_MAX : seq_length;

  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] m);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Scan step: check one map word from expected_pos up to len_eff.
  logic [ROW_W-1:0]  scan_row;
  logic [ROW_W-1:0]  len_row;
  logic [WORD_W-1:0] scan_mask;
  logic              scan_done;
  logic [POS_W-1:0]  scan_pos_next;

  assign scan_row = expected_pos[POS_W-1:BIT_W];
  assign len_row  = len_eff[POS_W-1:BIT_W];

  always_comb begin
    scan_mask = map_rdata & ({WORD_W{1'b1}} << expected_pos[BIT_W-1:0]);
    if (scan_row == len_row) begin
      scan_mask = scan_mask &
                  ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - len_eff[BIT_W-1:0]));
    end
    if (scan_mask != '0) begin
      scan_done     = 1'b1;
      scan_pos_next = {scan_row, first_one(scan_mask)};
    end else if (scan_row == len_row) begin
      scan_done     = 1'b1;
      scan_pos_next = len_eff + 1'b1;
    end else begin
      scan_done     = 1'b0;
      scan_pos_next = {scan_row + 1'b1, {BIT_W{1'b0}}};
    end
  end

  // Middle element grammar check.
  logic [TY_W-1:0]   prv;
  logic              mid_active;
  logic [ERR_W-1:0]  chk_code;
  logic [POS_W-1:0]  chk_node_next;
  logic [POS_W-1:0]  chk_pos_next;
  logic [POS_W-1:0]  node_ext;
  logic [TY_W-1:0]   entry_st;

  assign prv        = (held_st == TY_X) ? prior_st : held_st;
  assign mid_active = (mid_err == ERR_NONE) && (cur_st != TY_X);
  assign node_ext   = {1'b0, cur_node};
  assign entry_st   = (cur_st == TY_N) ? TY_S : TY_E;

  always_comb begin
    chk_code      = ERR_NONE;
    chk_node_next = expected_node;
    chk_pos_next  = expected_pos;
    case (cur_st)
      TY_S: chk_code = ERR_MID_S;
      TY_T: chk_code = ERR_MID_T;
      TY_N, TY_J, TY_C: begin
        if (cur_st != TY_J && core_mode) chk_code = ERR_CORE;
        else if (cur_node != '0) chk_code = ERR_NODE;
        else if (prv == entry_st) begin
          if (cur_pos != '0) chk_code = ERR_POS;
        end else if (prv == cur_st) begin
          if (cur_pos != expected_pos) chk_code = ERR_POS;
          else chk_pos_next = bump(expected_pos);
        end else begin
          chk_code = ERR_TRANS;
        end
      end
      TY_B: begin
        if (cur_node != '0) chk_code = ERR_NODE;
        else if (cur_pos != '0) chk_code = ERR_POS;
        else if (prv != TY_N && prv != TY_J) chk_code = ERR_TRANS;
      end
      TY_M: begin
        if (!core_mode && prv == TY_B) chk_node_next = node_ext;
        else chk_node_next = bump(expected_node);
        if (node_ext != chk_node_next) chk_code = ERR_NODE;
        else if (cur_pos != expected_pos) chk_code = ERR_POS;
        else if (prv != TY_B && prv != TY_M && prv != TY_D && prv != TY_I)
          chk_code = ERR_TRANS;
        else chk_pos_next = bump(expected_pos);
      end
      TY_D: begin
        chk_node_next = bump(expected_node);
        if (node_ext != chk_node_next) chk_code = ERR_NODE;
        else if (cur_pos != '0) chk_code = ERR_POS;
        else if (prv != TY_M && prv != TY_D && !(core_mode && prv == TY_B))
          chk_code = ERR_TRANS;
      end
      TY_I: begin
        if (node_ext != expected_node) chk_code = ERR_NODE;
        else if (cur_pos != expected_pos) chk_code = ERR_POS;
        else if (prv != TY_M && prv != TY_I && !(core_mode && prv == TY_B))
          chk_code = ERR_TRANS;
        else chk_pos_next = bump(expected_pos);
      end
      TY_E: begin
        if (cur_node != '0) chk_code = ERR_NODE;
        else if (cur_pos != '0) chk_code = ERR_POS;
        else if (prv != TY_M && prv != TY_D && !(core_mode && prv == TY_I))
          chk_code = ERR_TRANS;
      end
      default: chk_code = ERR_NONE;
    endcase
  end

  // Verdict priority.
  logic [ERR_W-1:0] fin_code;
  logic [TY_W-1:0]  want_last;

  assign want_last = core_mode ? TY_E : TY_T;

  always_comb begin
    if (elements_seen < 2'd2) fin_code = ERR_SHORT;
    else if (first_err[0]) fin_code = ERR_FIRST;
    else if (cur_st != want_last) fin_code = ERR_LAST;
    else if (first_err[1]) fin_code = ERR_FIRST_K;
    else if (first_err[2]) fin_code = ERR_FIRST_I;
    else if (cur_node != '0) fin_code = ERR_LAST_K;
    else if (cur_pos != '0) fin_code = ERR_LAST_I;
    else if (mid_err != ERR_NONE) fin_code = mid_err;
    else if (expected_pos <= len_eff) fin_code = ERR_RESIDUES;
    else fin_code = ERR_NONE;
  end

  // Map port control.
  always_comb begin
    map_req.we    = 1'b0;
    map_req.addr  = scan_row;
    map_req.wdata = map_rdata;
    case (state)
      S_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.addr  = clr_row;
        map_req.wdata = '0;
      end
      S_LOAD_RD: map_req.addr = ld_col[POS_W-1:BIT_W];
      S_LOAD_WR: begin
        map_req.we                       = 1'b1;
        map_req.addr                     = ld_col[POS_W-1:BIT_W];
        map_req.wdata[ld_col[BIT_W-1:0]] = ld_bit;
      end
      default: map_req.addr = scan_row;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      seq_length    <= '0;
      rsp_valid     <= 1'b0;
      elements_seen <= '0;
      core_mode     <= 1'b0;
      held_st       <= '0;
      prior_st      <= '0;
      expected_node <= '0;
      expected_pos  <= POS_W'(1);
      first_err     <= '0;
      mid_err       <= ERR_NONE;
    end else begin
      if (cfg_we) begin
        seq_length <= cfg_data;
      end
      // Drop the verdict once taken; a finishing step reloads it instead.
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur_st   <= state_type;
            cur_node <= model_node;
            cur_pos  <= seq_pos;
            cur_last <= last;
            ld_col   <= column;
            ld_bit   <= column_is_residue;
            if (!req_type) begin
              if (column <= LEN_MAX) state <= S_LOAD_RD;
            end else if (!last && elements_seen == 2'd0) begin
              // First element picks the mode; no scan.
              core_mode     <= (state_type == TY_B);
              first_err[0]  <= (state_type != TY_B) && (state_type != TY_S);
              first_err[1]  <= (model_node != '0);
              first_err[2]  <= (seq_pos != '0);
              prior_st      <= '0;
              held_st       <= state_type;
              elements_seen <= 2'd1;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_LOAD_RD: state <= S_LOAD_WR;
        S_LOAD_WR: state <= S_IDLE;
        S_SCAN_RD: begin
          if (expected_pos > len_eff) state <= cur_last ? S_FINISH : S_APPLY;
          else state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          expected_pos <= scan_pos_next;
          if (scan_done) state <= cur_last ? S_FINISH : S_APPLY;
          else state <= S_SCAN_RD;
        end
        S_APPLY: begin
          if (mid_active) begin
            mid_err       <= chk_code;
            expected_node <= chk_node_next;
            expected_pos  <= chk_pos_next;
          end
          prior_st <= held_st;
          held_st  <= cur_st;
          if (elements_seen != 2'd3) elements_seen <= elements_seen + 1'b1;
          state <= S_IDLE;
        end
        S_FINISH: begin
          // Hold until the output register is free.
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            path_ok       <= (fin_code == ERR_NONE);
            error_code    <= fin_code;
            elements_seen <= '0;
            core_mode     <= 1'b0;
            held_st       <= '0;
            prior_st      <= '0;
            expected_node <= '0;
            expected_pos  <= POS_W'(1);
            first_err     <= '0;
            mid_err       <= ERR_NONE;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HMMTV_ASSERT_NOW(a_ok_matches_code, rsp_valid, path_ok == (error_code == ERR_NONE), "path_ok disagrees with error_code")
  `HMMTV_ASSERT_NOW(a_busy_not_ready, state != S_IDLE, !req_ready, "ready while busy")
  `HMMTV_ASSERT_NEXT(a_finish_emits, state == S_FINISH && (!rsp_valid || rsp_ready), rsp_valid && elements_seen == 2'd0, "verdict not emitted or path not cleared")
endmodule

@@ sim/hmm_trace_validator_test.sv @@
// Self-checking testbench for hmm_trace_validator: map loads, alignment paths, verdicts.
// Depends on hmmtv_pkg and the hmm_trace_validator RTL; reads no files.
`timescale 1ns / 1ps
module hmm_trace_validator_test;
  import hmmtv_pkg::*;

  localparam int LATENCY_PAUSE = 300;   // covers the longest scan: 129 words
  localparam int WATCHDOG_MAX  = 4000;
  localparam int PHASE_ITEMS   = 225;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic              is_element;
    logic [POS_W-1:0]  col;
    logic              res;
    logic [TY_W-1:0]   st;
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  pos;
    logic              lst;
  } beat_t;

  typedef struct packed {
    logic             ok;
    logic [ERR_W-1:0] code;
  } verdict_t;

  logic              clk, rst;
  logic              cfg_we;
  logic [POS_W-1:0]  cfg_data;
  logic              req_valid, req_ready;
  logic              req_type;
  logic [POS_W-1:0]  column;
  logic              column_is_residue;
  logic [TY_W-1:0]   state_type;
  logic [NODE_W-1:0] model_node;
  logic [POS_W-1:0]  seq_pos;
  logic              last;
  logic              rsp_valid, rsp_ready;
  logic              path_ok;
  logic [ERR_W-1:0]  error_code;

  hmm_trace_validator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .column(column), .column_is_residue(column_is_residue),
    .state_type(state_type), .model_node(model_node), .seq_pos(seq_pos),
    .last(last), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .path_ok(path_ok), .error_code(error_code)
  );

  beat_t    pending_beats[$];
  verdict_t verdicts_due[$];
  int       send_idle_pct, recv_stall_pct;
  logic     beat_taken;
  int       mismatches;
  int       quiet_cycles;

  // ---------------------------------------------------------------------------
  // Path checker mirror: residue map, seq_length and per-path tracking state.
  // ---------------------------------------------------------------------------
  bit          mdl_map[MAX_SEQ_LEN+1];
  int unsigned mdl_len;
  int unsigned seen_cnt, in_core;
  int unsigned held_ty, held_node, held_pos, prior_ty;
  int unsigned want_node, want_pos, path_errs;

  function automatic int unsigned sat_inc(int unsigned v);
    return (v >= 8191) ? 8191 : v + 1;
  endfunction

  function automatic int unsigned clip_len(int unsigned len);
    return (len > MAX_SEQ_LEN) ? MAX_SEQ_LEN : len;
  endfunction

  task automatic clear_path_state();
    seen_cnt = 0; in_core = 0; held_ty = 0; held_node = 0; held_pos = 0;
    prior_ty = 0; want_node = 0; want_pos = 1; path_errs = 0;
  endtask

  // Grammar, node and position check of one middle element.
  function automatic int unsigned middle_fault(int unsigned st, int unsigned node,
                                               int unsigned pos, int unsigned prv);
    int unsigned entry;
    bit core;
    core = (in_core != 0);
    case (st)
      TY_S: return ERR_MID_S;
      TY_T: return ERR_MID_T;
      TY_N, TY_J, TY_C: begin
        entry = (st == TY_N) ? TY_S : TY_E;
        if (st != TY_J && core) return ERR_CORE;
        if (node != 0) return ERR_NODE;
        if (prv == entry) begin
          if (pos != 0) return ERR_POS;
        end else if (prv == st) begin
          if (pos != want_pos) return ERR_POS;
          want_pos = sat_inc(want_pos);
        end else return ERR_TRANS;
        return ERR_NONE;
      end
      TY_B: begin
        if (node != 0) return ERR_NODE;
        if (pos != 0) return ERR_POS;
        if (prv != TY_N && prv != TY_J) return ERR_TRANS;
        return ERR_NONE;
      end
      TY_M: begin
        if (!core && prv == TY_B) want_node = node;
        else want_node = sat_inc(want_node);
        if (node != want_node) return ERR_NODE;
        if (pos != want_pos) return ERR_POS;
        if (prv != TY_B && prv != TY_M && prv != TY_D && prv != TY_I) return ERR_TRANS;
        want_pos = sat_inc(want_pos);
        return ERR_NONE;
      end
      TY_D: begin
        want_node = sat_inc(want_node);
        if (node != want_node) return ERR_NODE;
        if (pos != 0) return ERR_POS;
        if (prv != TY_M && prv != TY_D && !(core && prv == TY_B)) return ERR_TRANS;
        return ERR_NONE;
      end
      TY_I: begin
        if (node != want_node) return ERR_NODE;
        if (pos != want_pos) return ERR_POS;
        if (prv != TY_M && prv != TY_I && !(core && prv == TY_B)) return ERR_TRANS;
        want_pos = sat_inc(want_pos);
        return ERR_NONE;
      end
      TY_E: begin
        if (node != 0) return ERR_NODE;
        if (pos != 0) return ERR_POS;
        if (prv != TY_M && prv != TY_D && !(core && prv == TY_I)) return ERR_TRANS;
        return ERR_NONE;
      end
      default: return ERR_NONE;
    endcase
  endfunction

  // Advance the mirror by one accepted beat; queue a verdict on a last element.
  task automatic track_beat(beat_t b);
    int unsigned st, node, pos, prev, prv, code, len, j;
    verdict_t v;
    st = b.st; node = b.node; pos = b.pos;
    if (!b.is_element) begin
      if (b.col >= 1 && b.col <= MAX_SEQ_LEN) mdl_map[b.col] = b.res;
      return;
    end
    if (!b.lst) begin
      if (seen_cnt == 0) begin
        in_core = (st == TY_B);
        if (st != TY_B && st != TY_S) path_errs |= 1;
        if (node != 0) path_errs |= 2;
        if (pos != 0) path_errs |= 4;
        prior_ty = 0;
      end else begin
        prev = held_ty;
        if ((path_errs >> 4) == 0) begin
          len = clip_len(mdl_len);
          while (want_pos <= len && !mdl_map[want_pos]) want_pos++;
          if (st != TY_X) begin
            prv = (prev == TY_X) ? prior_ty : prev;
            code = middle_fault(st, node, pos, prv);
            path_errs |= (code & 15) << 4;
          end
        end
        prior_ty = prev;
      end
      held_ty = st; held_node = node; held_pos = pos;
      if (seen_cnt < 3) seen_cnt++;
      return;
    end
    // Final element: rank the end checks above the first middle error.
    if (seen_cnt < 2) code = ERR_SHORT;
    else if (path_errs & 1) code = ERR_FIRST;
    else if (st != (in_core ? TY_E : TY_T)) code = ERR_LAST;
    else if (path_errs & 2) code = ERR_FIRST_K;
    else if (path_errs & 4) code = ERR_FIRST_I;
    else if (node != 0) code = ERR_LAST_K;
    else if (pos != 0) code = ERR_LAST_I;
    else if ((path_errs >> 4) != 0) code = (path_errs >> 4) & 15;
    else begin
      code = ERR_NONE;
      len = clip_len(mdl_len);
      for (j = want_pos; j <= len; j++)
        if (mdl_map[j]) begin
          code = ERR_RESIDUES;
          break;
        end
    end
    v.ok = (code == ERR_NONE);
    v.code = ERR_W'(code);
    verdicts_due.push_back(v);
    clear_path_state();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers. gen_map tracks what was loaded so paths can follow it.
  // ---------------------------------------------------------------------------
  bit          gen_map[MAX_SEQ_LEN+1];
  int unsigned gen_len;
  int unsigned gen_cursor;
  int          phase_items;

  task automatic push_load(int unsigned col, bit res);
    beat_t b;
    b = '0;
    b.col = POS_W'(col); b.res = res;
    b.st = TY_W'($urandom); b.node = NODE_W'($urandom); b.pos = POS_W'($urandom);
    b.lst = 1'($urandom);
    if (col >= 1 && col <= MAX_SEQ_LEN) gen_map[col] = res;
    pending_beats.push_back(b);
    phase_items++;
  endtask

  function automatic beat_t element(int unsigned st, int unsigned node,
                                    int unsigned pos, bit lst);
    beat_t b;
    b.is_element = 1'b1;
    b.col = POS_W'($urandom); b.res = 1'($urandom);
    b.st = TY_W'(st); b.node = NODE_W'(node); b.pos = POS_W'(pos); b.lst = lst;
    return b;
  endfunction

  task automatic push_elem(int unsigned st, int unsigned node, int unsigned pos, bit lst);
    pending_beats.push_back(element(st, node, pos, lst));
    phase_items++;
  endtask

  // Consume the next residue column after the cursor.
  function automatic int unsigned next_residue();
    int unsigned j;
    j = gen_cursor + 1;
    while (j <= gen_len && !gen_map[j]) j++;
    gen_cursor = (j > 8191) ? 8191 : j;
    return gen_cursor;
  endfunction

  // Build one match/insert/delete stretch, ending ready for E.
  task automatic add_domain(ref beat_t els[$], input bit core);
    int unsigned k, prev, r, n;
    k = core ? 1 : $urandom_range(1, 4000);
    els.push_back(element(TY_M, k, next_residue(), 0));
    prev = TY_M;
    n = $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 2);
      if (r == 1 && (prev == TY_M || prev == TY_I)) begin
        els.push_back(element(TY_I, k, next_residue(), 0)); prev = TY_I;
      end else if (r == 2 && (prev == TY_M || prev == TY_D)) begin
        k++; els.push_back(element(TY_D, k, 0, 0)); prev = TY_D;
      end else begin
        k++; els.push_back(element(TY_M, k, next_residue(), 0)); prev = TY_M;
      end
    end
    if (prev == TY_I && !core) begin
      k++; els.push_back(element(TY_M, k, next_residue(), 0));
    end
  endtask

  // Well-formed path with random content, sometimes broken on purpose.
  task automatic add_path(bit allow_damage);
    beat_t els[$];
    beat_t x;
    bit core;
    int unsigned idx;
    core = $urandom_range(0, 3) == 0;
    gen_cursor = 0;
    if (core) begin
      els.push_back(element(TY_B, 0, 0, 0));
      add_domain(els, 1);
      els.push_back(element(TY_E, 0, 0, 1));
    end else begin
      els.push_back(element(TY_S, 0, 0, 0));
      els.push_back(element(TY_N, 0, 0, 0));
      repeat ($urandom_range(0, 2)) els.push_back(element(TY_N, 0, next_residue(), 0));
      els.push_back(element(TY_B, 0, 0, 0));
      add_domain(els, 0);
      els.push_back(element(TY_E, 0, 0, 0));
      if ($urandom_range(0, 3) == 0) begin
        els.push_back(element(TY_J, 0, 0, 0));
        repeat ($urandom_range(0, 2)) els.push_back(element(TY_J, 0, next_residue(), 0));
        els.push_back(element(TY_B, 0, 0, 0));
        add_domain(els, 0);
        els.push_back(element(TY_E, 0, 0, 0));
      end
      els.push_back(element(TY_C, 0, 0, 0));
      // Usually account for every remaining residue so the path passes.
      if ($urandom_range(0, 4) != 0)
        while (gen_cursor < gen_len && els.size() < 80) begin
          idx = next_residue();
          if (idx <= gen_len) els.push_back(element(TY_C, 0, idx, 0));
        end
      els.push_back(element(TY_T, 0, 0, 1));
    end
    // Missing-data state somewhere between the first and the last element.
    if ($urandom_range(0, 4) == 0 && els.size() > 2) begin
      idx = $urandom_range(1, els.size() - 1);
      x = element(TY_X, $urandom, $urandom, 0);
      els.insert(idx, x);
    end
    if (allow_damage && $urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, els.size() - 1);
      case ($urandom_range(0, 3))
        0: els[idx].st = TY_W'($urandom);
        1: els[idx].node = NODE_W'($urandom);
        2: els[idx].pos = POS_W'($urandom);
        default: els[idx].pos = els[idx].pos + 1'b1;
      endcase
    end
    foreach (els[i]) begin
      pending_beats.push_back(els[i]);
      phase_items++;
    end
  endtask

  task automatic reload_map();
    int unsigned top;
    top = (gen_len < 40) ? gen_len : 40;
    for (int unsigned c = 1; c <= top; c++) push_load(c, $urandom_range(0, 9) < 7);
  endtask

  task automatic add_noise();
    beat_t b;
    b.is_element = 1'($urandom); b.col = POS_W'($urandom); b.res = 1'($urandom);
    b.st = TY_W'($urandom); b.node = NODE_W'($urandom); b.pos = POS_W'($urandom);
    b.lst = $urandom_range(0, 4) == 0;
    if (!b.is_element && b.col >= 1 && b.col <= MAX_SEQ_LEN) gen_map[b.col] = b.res;
    pending_beats.push_back(b);
    phase_items++;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || req_valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic write_length(int unsigned len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= POS_W'(len);
    mdl_len = len & 13'h1fff;
    gen_len = clip_len(mdl_len);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and sequence of phases.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned lengths[NUM_PHASES];
    lengths = '{12, 8191, 0, 4096, 30, 5000, 1, 64};
    rst = 1'b1; cfg_we = 1'b0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    mdl_len = 0; gen_len = 0;
    for (int i = 0; i <= MAX_SEQ_LEN; i++) begin
      mdl_map[i] = 0;
      gen_map[i] = 0;
    end
    clear_path_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on a 12-column sequence.
    write_length(lengths[0]);
    phase_items = 0;
    push_load(0, 1); push_load(4097, 1); push_load(8191, 1);   // out-of-range columns
    for (int unsigned c = 1; c <= 12; c++) push_load(c, (c % 3) != 0);
    push_elem(TY_T, 0, 0, 1);                                   // too short
    push_elem(TY_M, 5, 3, 0); push_elem(TY_M, 6, 1, 0);         // bad first element
    push_elem(TY_T, 0, 0, 1);
    push_elem(TY_S, 0, 0, 0); push_elem(TY_S, 0, 0, 0); push_elem(TY_T, 0, 0, 1);
    push_elem(TY_S, 0, 0, 0); push_elem(TY_T, 0, 0, 0); push_elem(TY_T, 0, 0, 1);
    push_elem(TY_B, 0, 0, 0); push_elem(TY_N, 0, 0, 0); push_elem(TY_E, 0, 0, 1);
    push_elem(TY_S, 0, 0, 0); push_elem(TY_N, 0, 0, 0); push_elem(4'd15, 9, 9, 0);
    push_elem(TY_X, 1, 1, 0); push_elem(TY_B, 0, 0, 0);         // lookback past X
    push_elem(TY_M, 4095, 1, 0); push_elem(TY_M, 4095, 2, 0);   // node runs past 4095
    push_elem(TY_T, 7, 3, 1);                                   // last node set
    add_path(0);
    add_path(0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        write_length(lengths[ph]);
        phase_items = 0;
      end
      set_idling(ph);
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) reload_map();
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_path(1);
        // Hold back so the queue does not run far ahead of the block.
        while (pending_beats.size() > 64) @(posedge clk);
      end
    end
    wait_drained();
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("hmm_trace_validator_test OK");
    else
      $display("hmm_trace_validator_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge; hold a beat until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
      req_type <= 1'b0;
      column <= '0;
      column_is_residue <= 1'b0;
      state_type <= '0;
      model_node <= '0;
      seq_pos <= '0;
      last <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (req_valid && !beat_taken) begin
        // hold the current beat
      end else if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        req_valid <= 1'b1;
        req_type <= b.is_element;
        column <= b.col;
        column_is_residue <= b.res;
        state_type <= b.st;
        model_node <= b.node;
        seq_pos <= b.pos;
        last <= b.lst;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, track accepted beats, check verdicts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t b;
    verdict_t v;
    bit moved;
    moved = cfg_we;
    if (rst) begin
      beat_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      beat_taken <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        b.is_element = req_type; b.col = column; b.res = column_is_residue;
        b.st = state_type; b.node = model_node; b.pos = seq_pos; b.lst = last;
        track_beat(b);
        moved = 1;
      end
      if (rsp_valid && rsp_ready) begin
        moved = 1;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected verdict: path_ok=%0d error_code=%0d", path_ok, error_code);
        end else begin
          v = verdicts_due.pop_front();
          if (path_ok !== v.ok || error_code !== v.code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict mismatch: expected ok=%0d code=%0d, got ok=%0d code=%0d",
                       v.ok, v.code, path_ok, error_code);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("hmm_trace_validator_test NOT OK");
        $finish;
      end
    end
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hmmtv_pkg.sv
rtl/hmmtv_map.sv
rtl/hmm_trace_validator.sv
sim/hmm_trace_validator_test.sv
